### design/pmsp_pkg.sv
// Package with the types, codes and constants of the permission mode string parser.
`default_nettype none

package pmsp_pkg;

  // One input word: a character of the mode string or the end mark.
  typedef struct packed {
    logic [7:0]  char_code;
    logic        end_mark;
    logic [11:0] base_mode;
  } pmsp_in_t;

  // One result word.
  typedef struct packed {
    logic [11:0] result_mode;
    logic [2:0]  error_code;
  } pmsp_out_t;

  typedef enum logic [2:0] {
    PH_START       = 3'd0,
    PH_OCTAL       = 3'd1,
    PH_WHO         = 3'd2,
    PH_AFTER_COMMA = 3'd3,
    PH_PERM        = 3'd4,
    PH_ERROR       = 3'd5
  } pmsp_phase_t;

  // Parser state carried from one character to the next.
  typedef struct packed {
    pmsp_phase_t phase;
    logic [11:0] working_mode;
    logic [2:0]  who_classes;
    logic [1:0]  pending_op;
    logic [2:0]  perm_bits;
    logic        perm_seen;
    logic        octal_overflow;
    logic [2:0]  held_error;
  } pmsp_state_t;

  localparam pmsp_state_t STATE_CLEAR = '{
    phase:          PH_START,
    working_mode:   12'd0,
    who_classes:    3'd0,
    pending_op:     2'd0,
    perm_bits:      3'd0,
    perm_seen:      1'b0,
    octal_overflow: 1'b0,
    held_error:     3'd0
  };

  localparam logic [2:0] ERR_NONE       = 3'd0;
  localparam logic [2:0] ERR_BAD_OCTAL  = 3'd1;
  localparam logic [2:0] ERR_BAD_OP     = 3'd2;
  localparam logic [2:0] ERR_NO_PERMS   = 3'd3;
  localparam logic [2:0] ERR_TRAIL_COMMA = 3'd4;
  localparam logic [2:0] ERR_UNEXPECTED = 3'd5;

  localparam logic [1:0] OP_NONE = 2'd0;
  localparam logic [1:0] OP_ADD  = 2'd1;
  localparam logic [1:0] OP_SUB  = 2'd2;
  localparam logic [1:0] OP_SET  = 2'd3;

  localparam logic [2:0] WHO_U   = 3'b100;
  localparam logic [2:0] WHO_G   = 3'b010;
  localparam logic [2:0] WHO_O   = 3'b001;
  localparam logic [2:0] WHO_ALL = 3'b111;

  localparam logic [2:0] PERM_R = 3'b100;
  localparam logic [2:0] PERM_W = 3'b010;
  localparam logic [2:0] PERM_X = 3'b001;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_U     = 8'h75;
  localparam logic [7:0] CH_G     = 8'h67;
  localparam logic [7:0] CH_O     = 8'h6F;
  localparam logic [7:0] CH_A     = 8'h61;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_EQUAL = 8'h3D;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_W     = 8'h77;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_COMMA = 8'h2C;

endpackage

`default_nettype wire

### design/pmsp_step.sv
// Per-character update of the parser state and the result of an end word.
`default_nettype none

module pmsp_step (
  input  pmsp_pkg::pmsp_in_t    in_word,
  input  pmsp_pkg::pmsp_state_t st,
  output pmsp_pkg::pmsp_state_t st_nxt,
  output pmsp_pkg::pmsp_out_t   res
);

  // Who letters and operators at the start of or inside the who list.
  function automatic pmsp_pkg::pmsp_state_t who_char(pmsp_pkg::pmsp_state_t s,
                                                     logic [7:0] c);
    pmsp_pkg::pmsp_state_t t;
    t = s;
    t.phase = pmsp_pkg::PH_WHO;
    unique case (c) inside
      pmsp_pkg::CH_U: t.who_classes = s.who_classes | pmsp_pkg::WHO_U;
      pmsp_pkg::CH_G: t.who_classes = s.who_classes | pmsp_pkg::WHO_G;
      pmsp_pkg::CH_O: t.who_classes = s.who_classes | pmsp_pkg::WHO_O;
      pmsp_pkg::CH_A: t.who_classes = pmsp_pkg::WHO_ALL;
      pmsp_pkg::CH_PLUS, pmsp_pkg::CH_MINUS, pmsp_pkg::CH_EQUAL: begin
        if (s.who_classes == 3'd0) begin
          t.who_classes = pmsp_pkg::WHO_ALL;
        end
        if (c == pmsp_pkg::CH_PLUS) begin
          t.pending_op = pmsp_pkg::OP_ADD;
        end else if (c == pmsp_pkg::CH_MINUS) begin
          t.pending_op = pmsp_pkg::OP_SUB;
        end else begin
          t.pending_op = pmsp_pkg::OP_SET;
        end
        t.phase = pmsp_pkg::PH_PERM;
      end
      default: begin
        t.held_error = pmsp_pkg::ERR_BAD_OP;
        t.phase      = pmsp_pkg::PH_ERROR;
      end
    endcase
    return t;
  endfunction

  logic [7:0]  c;
  logic        is_end;
  logic        is_digit;
  logic        is_big_digit;
  logic [2:0]  digit_val;
  logic [11:0] octal_next;
  logic [11:0] applied_mode;
  logic [2:0]  perm_char;
  logic        emit;
  logic [11:0] emit_mode;
  logic [2:0]  emit_err;

  assign c            = in_word.char_code;
  assign is_end       = in_word.end_mark;
  assign is_digit     = (c >= pmsp_pkg::CH_ZERO) && (c <= pmsp_pkg::CH_NINE);
  assign is_big_digit = (c >= pmsp_pkg::CH_EIGHT) && (c <= pmsp_pkg::CH_NINE);
  assign digit_val    = c[2:0];
  assign octal_next   = {st.working_mode[8:0], digit_val};

  always_comb begin
    unique case (c)
      pmsp_pkg::CH_R: perm_char = pmsp_pkg::PERM_R;
      pmsp_pkg::CH_W: perm_char = pmsp_pkg::PERM_W;
      pmsp_pkg::CH_X: perm_char = pmsp_pkg::PERM_X;
      default:        perm_char = 3'd0;
    endcase
  end

  // Apply the pending clause to each class that it names.
  always_comb begin
    applied_mode = st.working_mode;
    for (int i = 0; i < 3; i++) begin
      if (st.who_classes[i]) begin
        case (st.pending_op)
          pmsp_pkg::OP_ADD: applied_mode[3*i +: 3] = applied_mode[3*i +: 3] | st.perm_bits;
          pmsp_pkg::OP_SUB: applied_mode[3*i +: 3] = applied_mode[3*i +: 3] & ~st.perm_bits;
          pmsp_pkg::OP_SET: applied_mode[3*i +: 3] = st.perm_bits;
          default:          applied_mode[3*i +: 3] = applied_mode[3*i +: 3];
        endcase
      end
    end
  end

  always_comb begin
    st_nxt    = st;
    emit      = 1'b0;
    emit_mode = 12'd0;
    emit_err  = pmsp_pkg::ERR_NONE;
    unique case (st.phase) inside
      pmsp_pkg::PH_START: begin
        if (is_end) begin
          emit = 1'b1;
        end else if (is_digit) begin
          st_nxt.phase = pmsp_pkg::PH_OCTAL;
          if (is_big_digit) begin
            st_nxt.working_mode   = 12'd0;
            st_nxt.octal_overflow = 1'b1;
          end else begin
            st_nxt.working_mode = {9'd0, digit_val};
          end
        end else begin
          st_nxt = who_char('{
            phase:          pmsp_pkg::PH_START,
            working_mode:   in_word.base_mode,
            who_classes:    3'd0,
            pending_op:     pmsp_pkg::OP_NONE,
            perm_bits:      3'd0,
            perm_seen:      1'b0,
            octal_overflow: st.octal_overflow,
            held_error:     st.held_error
          }, c);
        end
      end
      pmsp_pkg::PH_OCTAL: begin
        if (is_end) begin
          emit      = 1'b1;
          emit_mode = st.working_mode;
          emit_err  = st.octal_overflow ? pmsp_pkg::ERR_BAD_OCTAL : pmsp_pkg::ERR_NONE;
        end else if (!is_digit) begin
          st_nxt.held_error = pmsp_pkg::ERR_BAD_OP;
          st_nxt.phase      = pmsp_pkg::PH_ERROR;
        end else if (!st.octal_overflow) begin
          // Shifting out a nonzero top digit means the value passed the limit.
          if (is_big_digit || (st.working_mode[11:9] != 3'd0)) begin
            st_nxt.octal_overflow = 1'b1;
          end else begin
            st_nxt.working_mode = octal_next;
          end
        end
      end
      pmsp_pkg::PH_WHO, pmsp_pkg::PH_AFTER_COMMA: begin
        if (is_end) begin
          emit     = 1'b1;
          emit_err = (st.phase == pmsp_pkg::PH_AFTER_COMMA) ?
                     pmsp_pkg::ERR_TRAIL_COMMA : pmsp_pkg::ERR_BAD_OP;
        end else begin
          st_nxt = who_char(st, c);
        end
      end
      pmsp_pkg::PH_PERM: begin
        if (!is_end && (perm_char != 3'd0)) begin
          st_nxt.perm_bits = st.perm_bits | perm_char;
          st_nxt.perm_seen = 1'b1;
        end else if ((st.pending_op != pmsp_pkg::OP_SET) && !st.perm_seen) begin
          if (is_end) begin
            emit     = 1'b1;
            emit_err = pmsp_pkg::ERR_NO_PERMS;
          end else begin
            st_nxt.held_error = pmsp_pkg::ERR_NO_PERMS;
            st_nxt.phase      = pmsp_pkg::PH_ERROR;
          end
        end else begin
          st_nxt.working_mode = applied_mode;
          if (is_end) begin
            emit      = 1'b1;
            emit_mode = applied_mode;
          end else if (c == pmsp_pkg::CH_COMMA) begin
            st_nxt.who_classes = 3'd0;
            st_nxt.pending_op  = pmsp_pkg::OP_NONE;
            st_nxt.perm_bits   = 3'd0;
            st_nxt.perm_seen   = 1'b0;
            st_nxt.phase       = pmsp_pkg::PH_AFTER_COMMA;
          end else begin
            st_nxt.held_error = pmsp_pkg::ERR_UNEXPECTED;
            st_nxt.phase      = pmsp_pkg::PH_ERROR;
          end
        end
      end
      default: begin
        // Error phase: swallow characters until the end word.
        if (is_end) begin
          emit     = 1'b1;
          emit_err = st.held_error;
        end
      end
    endcase
    if (emit) begin
      st_nxt = pmsp_pkg::STATE_CLEAR;
    end
  end

  assign res.result_mode = (emit_err == pmsp_pkg::ERR_NONE) ? emit_mode : 12'd0;
  assign res.error_code  = emit_err;

endmodule

`default_nettype wire

### design/permission_mode_string_parser_unit.sv
// Top level of the permission mode string parser: input register, parser state, result register.
`default_nettype none

// Channel   Direction  Word type   Handshake
// in_       input      pmsp_in_t   in_valid / in_stall
// out_      output     pmsp_out_t  out_valid / out_stall
//
// One word is taken every cycle unless an end word waits for output room; a character word
// updates the parser state in the cycle after it is taken, and an end word's result reaches
// out_valid via the input and output registers. The single parser state register sets the rate.
// Reset returns the parser to the start of a string and empties both registers.
// A stalled result holds the output register; the input register then holds only an end word.

module permission_mode_string_parser_unit (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire                 in_valid,
  output logic                in_stall,
  input  pmsp_pkg::pmsp_in_t  in_word,
  output logic                out_valid,
  input  wire                 out_stall,
  output pmsp_pkg::pmsp_out_t out_word
);

  logic                  in_valid_r;
  logic                  in_valid_nxt;
  pmsp_pkg::pmsp_in_t    in_word_r;
  pmsp_pkg::pmsp_state_t st_r;
  pmsp_pkg::pmsp_state_t st_nxt;
  pmsp_pkg::pmsp_out_t   res;
  logic                  out_valid_r;
  logic                  out_valid_nxt;
  pmsp_pkg::pmsp_out_t   out_word_r;
  logic                  out_free;
  logic                  advance;
  logic                  in_take;

  pmsp_step u_step (
    .in_word (in_word_r),
    .st      (st_r),
    .st_nxt  (st_nxt),
    .res     (res)
  );

  assign out_free = !out_valid_r || !out_stall;
  // A character word never waits; an end word needs room in the output register.
  assign advance  = in_valid_r && (!in_word_r.end_mark || out_free);
  assign in_stall = in_valid_r && !advance;
  assign in_take  = in_valid && !in_stall;

  assign in_valid_nxt  = in_take || (in_valid_r && !advance);
  assign out_valid_nxt = (out_valid_r && out_stall) || (advance && in_word_r.end_mark);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= pmsp_pkg::STATE_CLEAR;
    end else begin
      in_valid_r  <= in_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (advance) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_word_r <= in_word;
    end
    if (advance && in_word_r.end_mark) begin
      out_word_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

`default_nettype wire

### sim/tb_permission_mode_string_parser_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench of the permission mode string parser: mode strings under random flow control.
module tb_permission_mode_string_parser_unit;
  import pmsp_pkg::*;

  typedef logic [7:0] char_q_t[$];
  typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_style_t;

  localparam int CLK_HALF       = 5;
  localparam int RESET_CYCLES   = 9;
  localparam int WORD_TARGET    = 850;
  localparam int HOLD_CYCLES    = 80;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int REPORT_LINES   = 20;
  localparam int MODE_MAX       = 'o7777;
  localparam int OCTAL_RADIX    = 8;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  pmsp_in_t  in_word   = '0;
  logic      in_stall;
  logic      out_valid;
  logic      out_stall = 1'b0;
  pmsp_out_t out_word;

  // Parser state as the testbench predicts it.
  pmsp_phase_t p_phase;
  logic [11:0] p_mode;
  logic [2:0]  p_who;
  logic [1:0]  p_op;
  logic [2:0]  p_perms;
  logic        p_seen;
  logic        p_ovf;
  logic [2:0]  p_err;

  pmsp_out_t    expected_results[$];
  char_q_t      text_chars;
  stall_style_t stall_style = STALL_NONE;
  logic         hold_go     = 1'b0;
  int           hold_left   = 0;
  int           stall_phase = 0;
  int           idle_count  = 0;
  int           burst_left  = 0;
  bit           gaps_on     = 1'b0;
  int           words_sent      = 0;
  int           strings_sent    = 0;
  int           results_checked = 0;
  int           error_count     = 0;

  always #CLK_HALF clk = ~clk;

  permission_mode_string_parser_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  function automatic void clause_clear();
    p_who   = '0;
    p_op    = OP_NONE;
    p_perms = '0;
    p_seen  = 1'b0;
  endfunction

  function automatic void parser_clear();
    p_phase = PH_START;
    p_mode  = '0;
    p_ovf   = 1'b0;
    p_err   = ERR_NONE;
    clause_clear();
  endfunction

  function automatic void enter_error(input logic [2:0] code);
    p_err   = code;
    p_phase = PH_ERROR;
  endfunction

  // An end word closes the string: queue its result and start over.
  function automatic void close_string(input logic [11:0] mode, input logic [2:0] code);
    pmsp_out_t r;
    r.result_mode = (code == ERR_NONE) ? mode : 12'd0;
    r.error_code  = code;
    expected_results.push_back(r);
    parser_clear();
  endfunction

  function automatic void who_letter(input logic [7:0] c);
    case (c)
      CH_U: p_who |= WHO_U;
      CH_G: p_who |= WHO_G;
      CH_O: p_who |= WHO_O;
      CH_A: p_who = WHO_ALL;
      CH_PLUS, CH_MINUS, CH_EQUAL: begin
        if (p_who == '0) p_who = WHO_ALL;
        p_op = (c == CH_PLUS) ? OP_ADD : (c == CH_MINUS) ? OP_SUB : OP_SET;
        p_phase = PH_PERM;
        return;
      end
      default: begin
        enter_error(ERR_BAD_OP);
        return;
      end
    endcase
    p_phase = PH_WHO;
  endfunction

  function automatic void apply_clause();
    logic [11:0] m;
    logic [11:0] bits;
    logic [11:0] mask;
    m = p_mode;
    for (int k = 0; k < 3; k++) begin
      if (p_who[k]) begin
        bits = {9'd0, p_perms} << (3 * k);
        mask = 12'd7 << (3 * k);
        case (p_op)
          OP_ADD: m = m | bits;
          OP_SUB: m = m & ~bits;
          OP_SET: m = (m & ~mask) | bits;
          default: ;
        endcase
      end
    end
    p_mode = m;
  endfunction

  function automatic void advance_parser(input pmsp_in_t w);
    logic [7:0] c;
    bit         fin;
    bit         is_digit;
    int         d;
    int         v;
    c        = w.char_code;
    fin      = w.end_mark;
    is_digit = (c >= CH_ZERO) && (c <= CH_NINE);
    d        = int'(c) - int'(CH_ZERO);
    case (p_phase)
      PH_START: begin
        if (fin) begin
          close_string(12'd0, ERR_NONE);
        end else if (is_digit) begin
          p_mode = '0;
          if (d >= OCTAL_RADIX) p_ovf = 1'b1;
          else p_mode = 12'(d);
          p_phase = PH_OCTAL;
        end else begin
          p_mode = w.base_mode;
          clause_clear();
          who_letter(c);
        end
      end
      PH_OCTAL: begin
        if (fin) begin
          if (p_ovf) close_string(12'd0, ERR_BAD_OCTAL);
          else close_string(p_mode, ERR_NONE);
        end else if (!is_digit) begin
          enter_error(ERR_BAD_OP);
        end else if (!p_ovf) begin
          v = int'(p_mode) * OCTAL_RADIX + d;
          if (d >= OCTAL_RADIX || v > MODE_MAX) p_ovf = 1'b1;
          else p_mode = 12'(v);
        end
      end
      PH_WHO, PH_AFTER_COMMA: begin
        if (fin) close_string(12'd0, (p_phase == PH_AFTER_COMMA) ? ERR_TRAIL_COMMA : ERR_BAD_OP);
        else who_letter(c);
      end
      PH_PERM: begin
        if (!fin && (c == CH_R || c == CH_W || c == CH_X)) begin
          p_perms |= (c == CH_R) ? PERM_R : (c == CH_W) ? PERM_W : PERM_X;
          p_seen = 1'b1;
          return;
        end
        // Only an equals clause may stand without permission letters.
        if (p_op != OP_SET && !p_seen) begin
          if (fin) close_string(12'd0, ERR_NO_PERMS);
          else enter_error(ERR_NO_PERMS);
          return;
        end
        apply_clause();
        if (fin) begin
          close_string(p_mode, ERR_NONE);
        end else if (c == CH_COMMA) begin
          clause_clear();
          p_phase = PH_AFTER_COMMA;
        end else begin
          enter_error(ERR_UNEXPECTED);
        end
      end
      default: begin
        if (fin) close_string(12'd0, p_err);
      end
    endcase
  endfunction

  function automatic logic [7:0] pick_of(input logic [7:0] a, b, c, d);
    case ($urandom_range(0, 3))
      0: return a;
      1: return b;
      2: return c;
      default: return d;
    endcase
  endfunction

  function automatic logic [7:0] noise_char();
    if ($urandom_range(0, 1) != 0) return 8'($urandom_range(0, 255));
    return pick_of(CH_COMMA, pick_of(CH_U, CH_G, CH_O, CH_A),
                   pick_of(CH_PLUS, CH_MINUS, CH_EQUAL, CH_EIGHT),
                   pick_of(CH_R, CH_W, CH_X, CH_ZERO));
  endfunction

  // Mostly octal numbers and well-formed clause lists, some damaged, the rest noise.
  function automatic void fill_random_text();
    int kind;
    int n;
    kind = $urandom_range(0, 99);
    text_chars.delete();
    if (kind < 20) begin
      n = $urandom_range(1, 5);
      repeat (n) begin
        if ($urandom_range(0, 9) == 0) text_chars.push_back(pick_of(CH_EIGHT, CH_NINE,
                                                                     CH_EIGHT, CH_NINE));
        else text_chars.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
      end
      if (n > 1 && $urandom_range(0, 7) == 0)
        text_chars[$urandom_range(1, n - 1)] = noise_char();
    end else if (kind < 85) begin
      n = $urandom_range(1, 3);
      for (int k = 0; k < n; k++) begin
        if (k != 0) text_chars.push_back(CH_COMMA);
        repeat ($urandom_range(0, 3)) text_chars.push_back(pick_of(CH_U, CH_G, CH_O, CH_A));
        text_chars.push_back(pick_of(CH_PLUS, CH_MINUS, CH_EQUAL, CH_EQUAL));
        if ($urandom_range(0, 9) != 0)
          repeat ($urandom_range(1, 3)) text_chars.push_back(pick_of(CH_R, CH_W, CH_X, CH_R));
      end
      if ($urandom_range(0, 15) == 0) text_chars.push_back(CH_COMMA);
      if ($urandom_range(0, 15) == 0)
        text_chars[$urandom_range(0, text_chars.size() - 1)] = noise_char();
    end else begin
      repeat ($urandom_range(0, 6)) text_chars.push_back(noise_char());
    end
  endfunction

  // Sends one word; called and returning at a falling edge.
  task automatic send_word(input pmsp_in_t w);
    if (gaps_on && burst_left <= 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(negedge clk);
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_word  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    advance_parser(w);
    words_sent++;
    @(negedge clk);
  endtask

  // The base mode counts only on the first word, so later words carry random ones.
  task automatic send_text(input logic [11:0] base);
    pmsp_in_t w;
    foreach (text_chars[i]) begin
      w.char_code = text_chars[i];
      w.end_mark  = 1'b0;
      w.base_mode = (i == 0) ? base : 12'($urandom_range(0, 4095));
      send_word(w);
    end
    w.char_code = 8'($urandom_range(0, 255));
    w.end_mark  = 1'b1;
    w.base_mode = (text_chars.size() == 0) ? base : 12'($urandom_range(0, 4095));
    send_word(w);
    strings_sent++;
  endtask

  task automatic send_mode_string(input string s, input logic [11:0] base);
    text_chars.delete();
    for (int i = 0; i < s.len(); i++) text_chars.push_back(8'(s[i]));
    send_text(base);
  endtask

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < REPORT_LINES)
      $display("%0t: mismatch in %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  always @(posedge clk) begin : check_results
    pmsp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_checked++;
      if (expected_results.size() == 0) begin
        report_mismatch("result word with nothing expected, error code",
                        out_word.error_code, 0);
      end else begin
        want = expected_results.pop_front();
        if (out_word.result_mode !== want.result_mode)
          report_mismatch("result_mode", out_word.result_mode, want.result_mode);
        if (out_word.error_code !== want.error_code)
          report_mismatch("error_code", out_word.error_code, want.error_code);
      end
    end
  end

  always @(negedge clk) begin : drive_out_stall
    if (hold_go) begin
      hold_left = HOLD_CYCLES;
      hold_go <= 1'b0;
    end
    stall_phase++;
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      case (stall_style)
        STALL_LIGHT:    out_stall <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY:    out_stall <= ($urandom_range(0, 3) != 0);
        STALL_PERIODIC: out_stall <= ((stall_phase % 7) < 3);
        default:        out_stall <= 1'b0;
      endcase
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_count = 0;
    end else begin
      idle_count++;
      if (idle_count >= WATCHDOG_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  task automatic test_octal_strings();
    gaps_on = 1'b0;
    stall_style <= STALL_NONE;
    send_mode_string("", 12'hFFF);
    send_mode_string("7777", 12'h000);
    send_mode_string("10000", 12'h000);
    send_mode_string("9", 12'hFFF);
  endtask

  task automatic test_symbolic_clauses();
    stall_style <= STALL_LIGHT;
    send_mode_string("+rwx,u-w,o=", 12'hA00);
  endtask

  // Strings that end in a parse error: bad operator, missing permissions, trailing comma, unexpected character.
  task automatic test_parse_errors();
    gaps_on = 1'b1;
    send_mode_string("7u", 12'h000);
    send_mode_string("u", 12'hFFF);
    send_mode_string("+,", 12'hFFF);
    send_mode_string("=,", 12'h555);
    send_mode_string("-x+", 12'hFFF);
    text_chars.delete();
    text_chars.push_back(8'hFF);
    send_text(12'h000);
  endtask

  // The receiver holds off while strings keep coming, so the block has to stall its input.
  task automatic test_output_hold();
    gaps_on = 1'b0;
    stall_style <= STALL_NONE;
    hold_go <= 1'b1;
    in_valid <= 1'b0;
    @(negedge clk);
    repeat (8) begin
      fill_random_text();
      send_text(12'($urandom_range(0, 4095)));
    end
  endtask

  task automatic test_random_strings();
    int run;
    run = 0;
    while (words_sent < WORD_TARGET) begin
      if (run % 25 == 0) begin
        stall_style <= stall_style_t'($urandom_range(0, 3));
        gaps_on = ($urandom_range(0, 3) != 0);
      end
      fill_random_text();
      send_text(12'($urandom_range(0, 4095)));
      run++;
    end
  endtask

  initial begin
    parser_clear();
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_octal_strings();
    test_symbolic_clauses();
    test_parse_errors();
    test_output_hold();
    test_random_strings();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d mode strings in %0d words and checked %0d results.",
             strings_sent, words_sent, results_checked);
    $display("Octal, symbolic and error strings ran with gaps, random stalls and a long hold.");
    if (error_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

### files.f
design/pmsp_pkg.sv
design/pmsp_step.sv
design/permission_mode_string_parser_unit.sv
sim/tb_permission_mode_string_parser_unit.sv
